[src/smms_pkg.sv]
package smms_pkg;

  localparam int MAP_DIM_DEF    = 256;
  localparam int MAX_POINTS_DEF = 4096;
  localparam int CELL_BITS_DEF  = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_METER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_CELLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE     = 2'd3;

  localparam logic [23:0]        CPM_RESET    = 24'd1310720;
  localparam logic signed [24:0] ORIGIN_RESET = 25'sd8388608;
  localparam logic [8:0]         DIM_RESET    = 9'd256;

  localparam logic [26:0] SCORE_MAX = 27'h7FFFFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XL,
    S_XH,
    S_YL,
    S_YH,
    S_CHK,
    S_RD,
    S_MAC,
    S_SUM
  } state_t;

  typedef struct packed {
    logic       load;
    logic       wr;
    logic       mul_lo;
    logic       mul_hi;
    logic       mul_y;
    logic       chk;
    logic       rd;
    logic [1:0] idx;
    logic       mac;
    logic       sum;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic last;
  } sts_t;

endpackage

[src/smms_ctrl.sv]
module smms_ctrl
  import smms_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_command,
  input  logic out_ready,
  input  sts_t sts,
  output logic in_ready,
  output logic out_valid,
  output cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    k_nxt     = k_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command) begin
            cmd.load  = 1'b1;
            state_nxt = S_XL;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_XL: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_XH;
      end
      S_XH: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_YL;
      end
      S_YL: begin
        cmd.mul_lo = 1'b1;
        cmd.mul_y  = 1'b1;
        state_nxt  = S_YH;
      end
      S_YH: begin
        cmd.mul_hi = 1'b1;
        cmd.mul_y  = 1'b1;
        state_nxt  = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        k_nxt     = 2'd0;
        state_nxt = sts.in_range ? S_RD : S_SUM;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        cmd.idx   = k_r;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        k_nxt   = k_r + 2'd1;
        if (&k_r) begin
          state_nxt = S_SUM;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_SUM: begin
        if (!sts.last) begin
          cmd.sum   = 1'b1;
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.sum   = 1'b1;
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.emit | (out_valid_r & ~out_ready);
  end

  assign out_valid = out_valid_r;

endmodule

[src/smms_dp.sv]
module smms_dp
  import smms_pkg::*;
#(
  parameter int MAP_DIM    = MAP_DIM_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int CELL_BITS  = CELL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [7:0]            in_cell_row,
  input  logic [7:0]            in_cell_col,
  input  logic signed [15:0]    in_cell_value,
  input  logic signed [31:0]    in_point_x,
  input  logic signed [31:0]    in_point_y,
  input  logic signed [31:0]    in_offset_x,
  input  logic signed [31:0]    in_offset_y,
  input  logic                  in_last_point,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [26:0]           out_score,
  output logic [12:0]           out_valid_count
);

  localparam int IW        = $clog2(MAP_DIM);
  localparam int DEPTH     = 1 << (2 * IW);
  localparam int ACCW      = CELL_BITS + 34;
  localparam int COUNT_MAX = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;

  logic [CELL_BITS-1:0] mem [DEPTH];

  logic [23:0]        cpm_r;
  logic signed [24:0] origin_r;
  logic [8:0]         rows_r, cols_r;

  logic signed [32:0] wx_r, wy_r;
  logic               last_r;
  logic signed [57:0] px_r, py_r;
  logic [14:0]        fx_r, fy_r;
  logic [IW-1:0]      x0_r, y0_r;
  logic               in_range_r;
  logic signed [CELL_BITS-1:0] mem_q_r;
  logic [31:0]        wprod_r;
  logic signed [ACCW-1:0] acc_r;
  logic [26:0]        score_r, out_score_r;
  logic [12:0]        count_r, out_count_r;

  logic signed [32:0] mul_a;
  logic signed [12:0] mul_b;
  logic signed [45:0] mul_p;
  logic signed [57:0] lo_term, hi_term, org_term, p_sel;

  logic [31:0] rows_lim, cols_lim;
  logic        x_ok, y_ok;

  logic [31:0]   row_w, col_w;
  logic [23:0]   cell_ext;
  logic          wr_ok;

  logic [IW-1:0] rd_row, rd_col;
  logic [15:0]   gx, gy, wa, wb;

  logic signed [31:0]           wprod_s;
  logic signed [CELL_BITS+31:0] term;

  logic [CELL_BITS+2:0] val_u;
  logic                 val_neg;
  logic [27:0]          sum28;
  logic [26:0]          score_eff;
  logic [12:0]          count_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpm_r    <= CPM_RESET;
      origin_r <= ORIGIN_RESET;
      rows_r   <= DIM_RESET;
      cols_r   <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CELLS_PER_METER: cpm_r    <= cfg_data[23:0];
        REG_ORIGIN_CELLS:    origin_r <= signed'(cfg_data);
        REG_ROWS_IN_USE:     rows_r   <= cfg_data[8:0];
        REG_COLS_IN_USE:     cols_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign mul_a    = cmd.mul_y ? wy_r : wx_r;
  assign mul_b    = cmd.mul_hi ? signed'({1'b0, cpm_r[23:12]}) : signed'({1'b0, cpm_r[11:0]});
  assign mul_p    = mul_a * mul_b;
  assign lo_term  = {{12{mul_p[45]}}, mul_p};
  assign hi_term  = {mul_p, 12'b0};
  assign org_term = {{17{origin_r[24]}}, origin_r, 16'b0};
  assign p_sel    = cmd.mul_y ? py_r : px_r;

  assign rows_lim = (32'(rows_r) > 32'(MAP_DIM)) ? 32'(MAP_DIM) : 32'(rows_r);
  assign cols_lim = (32'(cols_r) > 32'(MAP_DIM)) ? 32'(MAP_DIM) : 32'(cols_r);
  assign x_ok     = !px_r[57] && ((32'(px_r[56:32]) + 32'd1) < cols_lim);
  assign y_ok     = !py_r[57] && ((32'(py_r[56:32]) + 32'd1) < rows_lim);

  assign sts.in_range = x_ok & y_ok;
  assign sts.last     = last_r;

  assign row_w    = 32'(in_cell_row);
  assign col_w    = 32'(in_cell_col);
  assign wr_ok    = (row_w < 32'(MAP_DIM)) && (col_w < 32'(MAP_DIM));
  assign cell_ext = {{8{in_cell_value[15]}}, in_cell_value};

  assign rd_row = y0_r + IW'(cmd.idx[0]);
  assign rd_col = x0_r + IW'(cmd.idx[1]);
  assign gx     = 16'd32768 - {1'b0, fx_r};
  assign gy     = 16'd32768 - {1'b0, fy_r};
  assign wa     = cmd.idx[1] ? {1'b0, fx_r} : gx;
  assign wb     = cmd.idx[0] ? {1'b0, fy_r} : gy;

  assign wprod_s = signed'({1'b0, wprod_r[30:0]});
  assign term    = wprod_s * mem_q_r;

  assign val_neg   = acc_r[ACCW-1];
  assign val_u     = acc_r[ACCW-2:30];
  assign sum28     = {1'b0, score_r} + 28'(val_u);
  assign score_eff = (in_range_r && !val_neg) ? (sum28[27] ? SCORE_MAX : sum28[26:0])
                                               : score_r;
  assign count_eff = (in_range_r && !val_neg && (count_r < 13'(COUNT_MAX)))
                     ? count_r + 13'd1 : count_r;

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem[{row_w[IW-1:0], col_w[IW-1:0]}] <= cell_ext[CELL_BITS-1:0];
    end
    if (cmd.rd) begin
      mem_q_r <= signed'(mem[{rd_row, rd_col}]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      wx_r   <= {in_point_x[31], in_point_x} + {in_offset_x[31], in_offset_x};
      wy_r   <= {in_point_y[31], in_point_y} + {in_offset_y[31], in_offset_y};
      last_r <= in_last_point;
    end
    if (cmd.mul_lo && !cmd.mul_y) px_r <= lo_term;
    if (cmd.mul_lo && cmd.mul_y)  py_r <= lo_term;
    if (cmd.mul_hi && !cmd.mul_y) px_r <= p_sel + hi_term + org_term;
    if (cmd.mul_hi && cmd.mul_y)  py_r <= p_sel + hi_term + org_term;
    if (cmd.chk) begin
      x0_r       <= px_r[32 +: IW];
      y0_r       <= py_r[32 +: IW];
      fx_r       <= px_r[31:17];
      fy_r       <= py_r[31:17];
      in_range_r <= x_ok & y_ok;
      acc_r      <= '0;
    end
    if (cmd.rd) begin
      wprod_r <= wa * wb;
    end
    if (cmd.mac) begin
      acc_r <= acc_r + {{(ACCW-CELL_BITS-32){term[CELL_BITS+31]}}, term};
    end
    if (cmd.emit) begin
      out_score_r <= score_eff;
      out_count_r <= count_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
      count_r <= '0;
    end else if (cmd.emit) begin
      score_r <= '0;
      count_r <= '0;
    end else if (cmd.sum) begin
      score_r <= score_eff;
      count_r <= count_eff;
    end
  end

  assign out_score       = out_score_r;
  assign out_valid_count = out_count_r;

endmodule

[src/scan_to_map_match_score.sv]
// Cell write words are accepted back to back.
// A scoring word runs four steps on the shared 33x13 multiplier, a bounds check,
// then a read and a multiply-accumulate for each of the four cells over the single
// memory read port, then the score update; a point outside the map skips to that update.
// A result word is shown from a register in the cycle after the last point's score update.
// Synchronous active-low reset clears control, configuration and sums; map contents stay.
module scan_to_map_match_score
  import smms_pkg::*;
#(
  parameter int MAP_DIM    = MAP_DIM_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int CELL_BITS  = CELL_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [7:0]            in_cell_row,
  input  logic [7:0]            in_cell_col,
  input  logic signed [15:0]    in_cell_value,
  input  logic signed [31:0]    in_point_x,
  input  logic signed [31:0]    in_point_y,
  input  logic signed [31:0]    in_offset_x,
  input  logic signed [31:0]    in_offset_y,
  input  logic                  in_last_point,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [26:0]           out_score,
  output logic [12:0]           out_valid_count,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int COUNT_LIM = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;

  cmd_t cmd;
  sts_t sts;

  smms_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_ready  (out_ready),
    .sts        (sts),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  smms_dp #(
    .MAP_DIM    (MAP_DIM),
    .MAX_POINTS (MAX_POINTS),
    .CELL_BITS  (CELL_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_cell_row     (in_cell_row),
    .in_cell_col     (in_cell_col),
    .in_cell_value   (in_cell_value),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_offset_x     (in_offset_x),
    .in_offset_y     (in_offset_y),
    .in_last_point   (in_last_point),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_score       (out_score),
    .out_valid_count (out_valid_count)
  );

`ifndef ASSERT_OFF
  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result word raised without an emit");

  a_busy_after_point: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command) |=> !in_ready)
    else $error("scoring word did not hold off the input");

  a_read_then_mac: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> (cmd.mac && !in_ready))
    else $error("cell read not followed by accumulate");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_valid_count) <= COUNT_LIM))
    else $error("valid count above its limit");
`endif

endmodule
